[src/assert_macros.svh]
// Assertion helpers. Both expect clk in scope; RTWE_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define RTWE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define RTWE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTWE_ASSERT(lbl, prop, msg)
`define RTWE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/rtwe_pkg.sv]
package rtwe_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned SCALED_W = 39;  // 32-bit distance times 100
  localparam int unsigned CLOCK_W  = 40;  // clamped clock + service + scaled closing leg

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // one stop after the input register, scaled legs precomputed
  typedef struct packed {
    logic                route_first;
    logic [FIELD_W-1:0]  start_time;
    logic [FIELD_W-1:0]  leg_distance;
    logic [SCALED_W-1:0] leg_scaled;
    logic [FIELD_W-1:0]  window_open;
    logic [FIELD_W-1:0]  window_close;
    logic [FIELD_W-1:0]  service_time;
    logic                route_last;
    logic [FIELD_W-1:0]  closing_distance;
    logic [SCALED_W-1:0] closing_scaled;
  } item_t;

  // route summary handed to the totals stage
  typedef struct packed {
    logic               bad;
    logic [CLOCK_W-1:0] clock;
    logic [SUM_W-1:0]   warp_sum;
    logic [SUM_W-1:0]   wait_sum;
    logic [FIELD_W-1:0] start_time;
    logic [SUM_W-1:0]   distance_sum;
  } res_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // x * 100 = x*64 + x*32 + x*4
  function automatic logic [SCALED_W-1:0] scale100(input logic [FIELD_W-1:0] x);
    logic [SCALED_W-1:0] xe;
    xe = {{(SCALED_W-FIELD_W){1'b0}}, x};
    return (xe << 6) + (xe << 5) + (xe << 2);
  endfunction

endpackage

[src/rtwe_in_stage.sv]
module rtwe_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [191:0]        in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  logic                take,
  output logic                item_valid,
  output rtwe_pkg::item_t     item
);

  logic            valid_r;
  rtwe_pkg::item_t item_r;
  rtwe_pkg::item_t item_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    item_nxt.route_first      = in_tuser;
    item_nxt.start_time       = in_tdata[31:0];
    item_nxt.leg_distance     = in_tdata[63:32];
    item_nxt.leg_scaled       = rtwe_pkg::scale100(in_tdata[63:32]);
    item_nxt.window_open      = in_tdata[95:64];
    item_nxt.window_close     = in_tdata[127:96];
    item_nxt.service_time     = in_tdata[159:128];
    item_nxt.route_last       = in_tlast;
    item_nxt.closing_distance = in_tdata[191:160];
    item_nxt.closing_scaled   = rtwe_pkg::scale100(in_tdata[191:160]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/rtwe_core.sv]
`include "assert_macros.svh"

module rtwe_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  logic                item_valid,
  input  rtwe_pkg::item_t     item,
  output logic                take,
  output logic                res_valid,
  output rtwe_pkg::res_t      res,
  input  logic                res_ready
);

  localparam int unsigned FW = rtwe_pkg::FIELD_W;
  localparam int unsigned SW = rtwe_pkg::SUM_W;
  localparam int unsigned CW = rtwe_pkg::CLOCK_W;

  logic [FW-1:0]  end_time_r;
  logic [CW-1:0]  clock_r, clock_nxt;
  logic [FW-1:0]  start_r, start_nxt;
  logic [SW-1:0]  wait_r, wait_nxt;
  logic [SW-1:0]  warp_r, warp_nxt;
  logic [SW-1:0]  dist_r, dist_nxt;
  logic           failed_r, failed_nxt;
  logic           res_valid_r;
  rtwe_pkg::res_t res_r, res_nxt;

  logic           fire;
  logic [CW:0]    arrive;      // clock + 100 * leg
  logic           early, late;
  logic [FW-1:0]  clamped;
  logic [FW:0]    served;
  logic [CW-1:0]  closed;
  logic           fail_served, fail_closed, add_closing;
  logic [SW+1:0]  dist_sum;

  // a last stop needs the result slot, other stops never wait
  assign take = item_valid && (!item.route_last || !res_valid_r || res_ready);
  assign fire = item_valid && take;

  always_comb begin
    arrive      = {1'b0, clock_r} + {{(CW+1-rtwe_pkg::SCALED_W){1'b0}}, item.leg_scaled};
    early       = arrive < {{(CW+1-FW){1'b0}}, item.window_open};
    late        = !early && (arrive > {{(CW+1-FW){1'b0}}, item.window_close});
    // after the clamp the clock exceeds the window close only when window_open does
    clamped     = early ? item.window_open : (late ? item.window_close : arrive[FW-1:0]);
    served      = {1'b0, clamped} + {1'b0, item.service_time};
    closed      = {{(CW-FW-1){1'b0}}, served}
                  + {{(CW-rtwe_pkg::SCALED_W){1'b0}}, item.closing_scaled};
    fail_served = served > {1'b0, end_time_r};
    fail_closed = closed > {{(CW-FW){1'b0}}, end_time_r};
    add_closing = item.route_last && !fail_closed;
    dist_sum    = {2'b00, dist_r} + {{(SW+2-FW){1'b0}}, item.leg_distance}
                  + (add_closing ? {{(SW+2-FW){1'b0}}, item.closing_distance} : '0);

    clock_nxt  = clock_r;
    start_nxt  = start_r;
    wait_nxt   = wait_r;
    warp_nxt   = warp_r;
    dist_nxt   = dist_r;
    failed_nxt = failed_r;

    res_nxt.bad          = 1'b0;
    res_nxt.clock        = clock_r;
    res_nxt.warp_sum     = warp_r;
    res_nxt.wait_sum     = wait_r;
    res_nxt.start_time   = start_r;
    res_nxt.distance_sum = dist_r;

    if (item.route_first) begin
      clock_nxt  = {{(CW-FW){1'b0}}, item.start_time};
      start_nxt  = item.start_time;
      wait_nxt   = '0;
      warp_nxt   = '0;
      dist_nxt   = '0;
      failed_nxt = 1'b0;
      // depot-only route: start minus start gives zero time
      res_nxt.clock        = {{(CW-FW){1'b0}}, item.start_time};
      res_nxt.warp_sum     = '0;
      res_nxt.wait_sum     = '0;
      res_nxt.start_time   = item.start_time;
      res_nxt.distance_sum = '0;
    end else if (failed_r) begin
      res_nxt.bad = 1'b1;
    end else begin
      if (early) begin
        wait_nxt = rtwe_pkg::sat_add(wait_r,
                     {{(SW-FW){1'b0}}, item.window_open - arrive[FW-1:0]});
      end
      if (late) begin
        warp_nxt = rtwe_pkg::sat_add(warp_r,
                     {{(SW-CW-1){1'b0}}, arrive - {{(CW+1-FW){1'b0}}, item.window_close}});
      end
      if (fail_served) begin
        clock_nxt  = {{(CW-FW-1){1'b0}}, served};
        failed_nxt = 1'b1;
      end else begin
        clock_nxt  = item.route_last ? closed : {{(CW-FW-1){1'b0}}, served};
        failed_nxt = item.route_last && fail_closed;
        dist_nxt   = (dist_sum[SW+1:SW] != 2'b00) ? rtwe_pkg::SUM_MAX : dist_sum[SW-1:0];
      end
      res_nxt.bad          = fail_served || fail_closed;
      res_nxt.clock        = closed;
      res_nxt.warp_sum     = warp_nxt;
      res_nxt.wait_sum     = wait_nxt;
      res_nxt.distance_sum = dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_time_r  <= '1;
      clock_r     <= '0;
      start_r     <= '0;
      wait_r      <= '0;
      warp_r      <= '0;
      dist_r      <= '0;
      failed_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        end_time_r <= cfg_wr_data;
      end
      if (fire) begin
        clock_r  <= clock_nxt;
        start_r  <= start_nxt;
        wait_r   <= wait_nxt;
        warp_r   <= warp_nxt;
        dist_r   <= dist_nxt;
        failed_r <= failed_nxt;
      end
      if (fire && item.route_last) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item.route_last) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `RTWE_ASSERT(a_last_gives_result, fire && item.route_last |=> res_valid_r, "last stop lost")
  `RTWE_ASSERT(a_stall_holds, res_valid_r && !res_ready |=> res_valid_r && $stable(res_r), "summary changed while stalled")
  `RTWE_ASSERT(a_failed_sticks, failed_r && fire && !item.route_first |=> failed_r, "failure cleared mid-route")
  `RTWE_ASSERT(a_no_spurious, fire && !item.route_last && (!res_valid_r || res_ready) |=> !res_valid_r, "result without last stop")
  `RTWE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !res_valid_r && !failed_r, "reset left state")

endmodule

[src/rtwe_total.sv]
module rtwe_total (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  rtwe_pkg::res_t      res,
  output logic                res_ready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [95:0]         out_tdata,
  output logic                out_tuser
);

  localparam int unsigned FW = rtwe_pkg::FIELD_W;
  localparam int unsigned SW = rtwe_pkg::SUM_W;
  localparam int unsigned CW = rtwe_pkg::CLOCK_W;

  logic          out_valid_r;
  logic          bad_r;
  logic [SW-1:0] time_r, time_nxt;
  logic [SW-1:0] dist_r;
  logic [SW-1:0] with_warp, elapsed;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    with_warp = rtwe_pkg::sat_add({{(SW-CW){1'b0}}, res.clock}, res.warp_sum);
    // floor at zero if the sum falls below the start
    elapsed   = (with_warp >= {{(SW-FW){1'b0}}, res.start_time})
                ? with_warp - {{(SW-FW){1'b0}}, res.start_time} : '0;
    time_nxt  = rtwe_pkg::sat_add(elapsed, res.wait_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      bad_r  <= res.bad;
      time_r <= res.bad ? '0 : time_nxt;
      dist_r <= res.bad ? '0 : res.distance_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {dist_r, time_r};
  assign out_tuser  = bad_r;

endmodule

[src/route_time_window_evaluator_top.sv]
// Route time-window evaluator: one stop per transfer, every cycle unless a last stop stalls.
// A last stop's result reaches out_* through the input register, the route state
// update (result slot) and the totals register.
// Throughput: one stop per cycle, limited only by out_tready stalls on last stops.
// Reset (rst_n low, synchronous): route state cleared, end_time set to all ones,
// no result pending.
module route_time_window_evaluator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,     // end_time
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_time, leg_distance, window_open, window_close, service_time, closing_distance
  input  logic [191:0] in_tdata,
  input  logic         in_tuser,        // route_first
  input  logic         in_tlast,        // route_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,       // total_time, total_distance
  output logic         out_tuser        // infeasible
);

  logic            take;
  logic            item_valid;
  rtwe_pkg::item_t item;
  logic            res_valid;
  logic            res_ready;
  rtwe_pkg::res_t  res;

  rtwe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rtwe_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  rtwe_total u_total (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
